// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// File: rtl/smpq_pkg.sv
`default_nettype none
package smpq_pkg;
   localparam int DEPTH_DEFAULT = 16;
   localparam int PAYLOAD_BITS  = 36;
   localparam int COST_BITS     = 10;
   localparam int KEY_BITS      = COST_BITS + 1;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_GOT      = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic                    op;
      logic [PAYLOAD_BITS-1:0] payload;
      logic [COST_BITS-1:0]    cost_so_far;
      logic [COST_BITS-1:0]    heuristic;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [PAYLOAD_BITS-1:0] payload_out;
      logic [KEY_BITS-1:0]     key_out;
   } rsp_type;

   typedef struct packed {
      logic [PAYLOAD_BITS-1:0] payload;
      logic [KEY_BITS-1:0]     key;
   } entry_type;
endpackage
`default_nettype wire

// File: rtl/stable_min_priority_queue.sv
// Open list for a best-first search. Entries sit in a single-port-write,
// registered-read memory in arrival order, slots 0 to occupancy-1. On an
// enqueue the entry is written behind the last slot and its result is
// registered at once. A dequeue scans the stored entries with one memory
// read a cycle, keeping the lowest slot with the smallest key, then closes
// the gap by moving each later entry down one slot, reading it in S_SH_RD
// and writing it in S_SH_WR, and returns the removed entry. A new item is
// taken only while no dequeue is in progress and the result register is
// free or being emptied. Equal keys leave in arrival order. Dequeue on an
// empty queue reports empty, and enqueue on a full one reports full and
// drops the entry.
`default_nettype none
`include "assert_macros.svh"
module stable_min_priority_queue
   import smpq_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW:0] DEPTH_CNT = (AW+1)'(DEPTH);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SH_RD = 2'd2;
   localparam logic [1:0] S_SH_WR = 2'd3;

   entry_type mem [DEPTH];
   entry_type rdata_ff;

   logic [1:0]    state_ff, state_in;
   logic [AW:0]   occ_ff, occ_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   entry_type     best_ff, best_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   // Slot of the current best entry during the scan.
   logic [AW-1:0] best_idx_ff, best_idx_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic [AW-1:0] rd_addr;

   logic out_free, accept, take, last;
   logic [AW:0] ptr_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign accept    = req_valid && !req_stall;
   assign ptr_next  = {1'b0, ptr_ff} + (AW+1)'(1);
   assign take      = (ptr_ff == '0) || (rdata_ff.key < best_ff.key);
   assign last      = (ptr_next == occ_ff);

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      ptr_in       = ptr_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = rdata_ff;
      rd_addr      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.op == OP_ENQ) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  if (occ_ff == DEPTH_CNT) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status     = ST_INSERTED;
                     mem_we            = 1'b1;
                     mem_waddr         = occ_ff[AW-1:0];
                     mem_wdata.payload = req_data.payload;
                     mem_wdata.key     = KEY_BITS'(req_data.cost_so_far)
                                       + KEY_BITS'(req_data.heuristic);
                     occ_in            = occ_ff + (AW+1)'(1);
                  end
               end else if (occ_ff == '0) begin
                  rsp_valid_in  = 1'b1;
                  rsp_in        = '0;
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rd_addr  = '0;
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rdata_ff holds the slot at ptr_ff, read in the previous cycle.
            if (take) begin
               best_in = rdata_ff;
            end
            if (last) begin
               // Strict less-than keeps the earliest slot among equal keys.
               if (!take) begin
                  ptr_in = best_idx_ff;
               end
               state_in = S_SH_RD;
            end else begin
               rd_addr  = ptr_next[AW-1:0];
               ptr_in   = ptr_next[AW-1:0];
               state_in = S_SCAN;
            end
         end
         S_SH_RD: begin
            if (ptr_next >= occ_ff) begin
               occ_in              = occ_ff - (AW+1)'(1);
               rsp_valid_in        = 1'b1;
               rsp_in.status       = ST_GOT;
               rsp_in.payload_out  = best_ff.payload;
               rsp_in.key_out      = best_ff.key;
               state_in            = S_IDLE;
            end else begin
               rd_addr  = ptr_next[AW-1:0];
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff;
            mem_wdata = rdata_ff;
            ptr_in    = ptr_next[AW-1:0];
            state_in  = S_SH_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign best_idx_in = (state_ff == S_SCAN && take) ? ptr_ff : best_idx_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff      <= ptr_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEVER(a_occ_bound, clock, reset, occ_ff > DEPTH_CNT)
   `ASSERT_NEVER(a_busy_no_rsp, clock, reset, state_ff != S_IDLE && rsp_valid_ff)
   `ASSERT_CLK(a_empty_rsp, clock, reset, accept && req_data.op == OP_DEQ && occ_ff == '0 |=> rsp_valid_ff && rsp_ff.status == ST_EMPTY)
   `ASSERT_CLK(a_enq_count, clock, reset, accept && req_data.op == OP_ENQ && occ_ff != DEPTH_CNT |=> occ_ff == $past(occ_ff) + (AW+1)'(1))
endmodule
`default_nettype wire
